FILE: hdl/tcsf_pkg.sv
// Shared types, constants and helper function for the triangle column span filler.
`default_nettype none
package tcsf_pkg;

  localparam int FRAC_BITS    = 4;
  localparam int COLUMN_BITS  = 12;
  localparam int COORD_BITS   = 16;
  localparam int COL_CNT_BITS = COLUMN_BITS + 1;
  localparam int COLUMN_LIMIT = 1 << COLUMN_BITS;
  localparam int XW_BITS      = COL_CNT_BITS + FRAC_BITS;

  // Edge arithmetic widths
  localparam int DY_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * DY_BITS;
  localparam int NSUM_BITS = PROD_BITS + 2;
  localparam int QUO_BITS  = COORD_BITS + 1;
  localparam int DEN_BITS  = COORD_BITS + 1;
  localparam int NUM_BITS  = QUO_BITS + DEN_BITS;
  localparam int YS_BITS   = COORD_BITS + 3;
  localparam int DIV_CNT_BITS = $clog2(QUO_BITS + 1);

  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

  typedef struct packed {
    logic                  cmd;
    logic [COORD_BITS-1:0] vertex_x;
    logic [COORD_BITS-1:0] vertex_y;
  } tcsf_in_t;

  typedef struct packed {
    logic [COLUMN_BITS-1:0] column;
    logic [COORD_BITS-1:0]  span_start_y;
    logic [COORD_BITS-1:0]  span_end_y;
    logic                   drawn;
    logic                   last_span;
    logic                   past_end;
  } tcsf_out_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SPAN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LONG,
    ST_START_LONG,
    ST_WAIT_LONG,
    ST_MUL_SHORT,
    ST_START_SHORT,
    ST_WAIT_SHORT
  } tcsf_state_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;
    logic quick;
    logic mul;
    logic edge_short;
    logic div_start;
    logic cap_long;
    logic cap_short;
  } tcsf_ctrl_t;

  // Datapath status to the controller
  typedef struct packed {
    logic active;
    logic flat;
    logic div_done;
  } tcsf_status_t;

  function automatic logic [COL_CNT_BITS-1:0] ceil_col(input logic [COORD_BITS-1:0] x);
    logic [COORD_BITS:0] s;
    s = {1'b0, x} + (COORD_BITS+1)'((1 << FRAC_BITS) - 1);
    s = s >> FRAC_BITS;
    if (s > (COORD_BITS+1)'(COLUMN_LIMIT)) begin
      return COL_CNT_BITS'(COLUMN_LIMIT);
    end
    return COL_CNT_BITS'(s);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/triangle_column_span_fill.sv
// Top level of the triangle column span filler: controller plus datapath.
//
// A transfer is taken when start_i is high and busy_o is low. A vertex load
// (cmd 0) is absorbed in that cycle and gives no result; busy_o stays low. A
// span request (cmd 1) gives exactly one result, shown on res_o for a single
// cycle with strobe_o high; there is no backpressure, so capture it then.
// Past-end answers and flat triangles come back in the cycle after the
// transfer. A regular column evaluates the long edge and then the short edge
// on one shared multiplier and a bit-serial divider that yields one quotient
// bit per cycle, with coordinates in 12.4 format; busy_o is high while the
// span is evaluated. Vertices are sorted by x as the third one loads.
`default_nettype none
module triangle_column_span_fill (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire tcsf_pkg::tcsf_in_t   req_i,
  output logic                      busy_o,
  output logic                      strobe_o,
  output tcsf_pkg::tcsf_out_t       res_o
);
  import tcsf_pkg::*;

  tcsf_ctrl_t   ctrl;
  tcsf_status_t status;

  // Sequence loads and edge evaluations
  tcsf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (req_i.cmd),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy_o)
  );

  // Hold vertices, box and column; compute edge values
  tcsf_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .ctrl_i   (ctrl),
    .status_o (status),
    .strobe_o (strobe_o),
    .res_o    (res_o)
  );

endmodule
`default_nettype wire

FILE: hdl/tcsf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module tcsf_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [tcsf_pkg::NUM_BITS-1:0] num_i,
  input  wire logic [tcsf_pkg::DEN_BITS-1:0] den_i,
  output logic                               done_o,
  output logic [tcsf_pkg::QUO_BITS-1:0]      quo_o,
  output logic                               rem_nz_o
);
  import tcsf_pkg::*;

  logic [DEN_BITS-1:0]     rem_q, rem_d, den_q;
  logic [QUO_BITS-1:0]     quo_q, quo_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic                    run_q, run_d, done_q, done_d;
  logic [DEN_BITS:0]       trial, diff;
  logic                    ge;

  always_comb begin
    trial = {rem_q, quo_q[QUO_BITS-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = num_i[NUM_BITS-1:QUO_BITS];
      quo_d = num_i[QUO_BITS-1:0];
      cnt_d = DIV_CNT_BITS'(QUO_BITS);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
      quo_d = {quo_q[QUO_BITS-2:0], ge};
      cnt_d = cnt_q - DIV_CNT_BITS'(1);
      if (cnt_q == DIV_CNT_BITS'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = |rem_q;

endmodule
`default_nettype wire

FILE: hdl/tcsf_datapath.sv
// Datapath: vertex store, bounding box, column counter, edge multiplier and divider.
`default_nettype none
module tcsf_datapath (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tcsf_pkg::tcsf_in_t     req_i,
  input  wire tcsf_pkg::tcsf_ctrl_t   ctrl_i,
  output tcsf_pkg::tcsf_status_t      status_o,
  output logic                        strobe_o,
  output tcsf_pkg::tcsf_out_t         res_o
);
  import tcsf_pkg::*;

  logic [COORD_BITS-1:0]   vx_q [3];
  logic [COORD_BITS-1:0]   vy_q [3];
  logic [COORD_BITS-1:0]   nx [3];
  logic [COORD_BITS-1:0]   ny [3];
  logic [COORD_BITS-1:0]   tmp_x, tmp_y;
  logic [1:0]              loaded_q, slot;
  logic [COL_CNT_BITS-1:0] next_col_q, end_col_q, col_inc;
  logic [COORD_BITS-1:0]   box_min_q, box_max_q, bmin, bmax;
  logic                    active_q, flat_q;

  logic [XW_BITS-1:0]          big_x;
  logic                        short_lo;
  logic [COORD_BITS-1:0]       xa, xb, ya, yb;
  logic signed [DY_BITS-1:0]   dy, tt;
  logic signed [PROD_BITS-1:0] prod_q;
  logic [COORD_BITS-1:0]       ya_q, dx_q;
  logic signed [NSUM_BITS-1:0] nsum, nmag;
  logic                        neg_q;
  logic [COORD_BITS-1:0]       ylong_q, y_edge;

  logic                        div_done, rem_nz;
  logic [QUO_BITS-1:0]         quo;
  logic signed [YS_BITS-1:0]   qmag, qinc, qs, ys;

  logic                        strobe_q;
  tcsf_out_t                   res_q, res_d;
  logic [COL_CNT_BITS-1:0]     flat_col;

  // Load slot and sorted copy of the vertex set
  always_comb begin
    tmp_x = '0;
    tmp_y = '0;
    slot = (loaded_q == 2'd3) ? 2'd0 : loaded_q;
    bmin = (slot == 2'd0) ? req_i.vertex_y
         : ((req_i.vertex_y < box_min_q) ? req_i.vertex_y : box_min_q);
    bmax = (slot == 2'd0) ? req_i.vertex_y
         : ((req_i.vertex_y > box_max_q) ? req_i.vertex_y : box_max_q);
    for (int i = 0; i < 3; i++) begin
      nx[i] = vx_q[i];
      ny[i] = vy_q[i];
    end
    nx[slot] = req_i.vertex_x;
    ny[slot] = req_i.vertex_y;
    if (slot == 2'd2) begin
      if (nx[0] > nx[1]) begin
        tmp_x = nx[0]; tmp_y = ny[0];
        nx[0] = nx[1]; ny[0] = ny[1];
        nx[1] = tmp_x; ny[1] = tmp_y;
      end
      if (nx[1] > nx[2]) begin
        tmp_x = nx[1]; tmp_y = ny[1];
        nx[1] = nx[2]; ny[1] = ny[2];
        nx[2] = tmp_x; ny[2] = tmp_y;
      end
      if (nx[0] > nx[1]) begin
        tmp_x = nx[0]; tmp_y = ny[0];
        nx[0] = nx[1]; ny[0] = ny[1];
        nx[1] = tmp_x; ny[1] = tmp_y;
      end
    end
  end

  // Edge operand selection
  always_comb begin
    big_x    = XW_BITS'(next_col_q) << FRAC_BITS;
    short_lo = big_x < XW_BITS'(vx_q[1]);
    if (!ctrl_i.edge_short) begin
      xa = vx_q[0]; ya = vy_q[0]; xb = vx_q[2]; yb = vy_q[2];
    end else if (short_lo) begin
      xa = vx_q[0]; ya = vy_q[0]; xb = vx_q[1]; yb = vy_q[1];
    end else begin
      xa = vx_q[1]; ya = vy_q[1]; xb = vx_q[2]; yb = vy_q[2];
    end
    dy = $signed({1'b0, yb}) - $signed({1'b0, ya});
    tt = $signed({1'b0, COORD_BITS'(big_x - XW_BITS'(xa))});
  end

  // Rounded numerator 2*dy*t + dx and its magnitude
  always_comb begin
    nsum = $signed({prod_q[PROD_BITS-1], prod_q, 1'b0})
         + $signed(NSUM_BITS'(dx_q));
    nmag = nsum[NSUM_BITS-1] ? -nsum : nsum;
  end

  tcsf_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ctrl_i.div_start),
    .num_i    (nmag[NUM_BITS-1:0]),
    .den_i    ({dx_q, 1'b0}),
    .done_o   (div_done),
    .quo_o    (quo),
    .rem_nz_o (rem_nz)
  );

  // Floor quotient, add the start y, clamp to the coordinate range
  always_comb begin
    qmag = $signed(YS_BITS'(quo));
    qinc = qmag + $signed(YS_BITS'(rem_nz));
    qs   = neg_q ? -qinc : qmag;
    ys   = $signed(YS_BITS'(ya_q)) + qs;
    if (ys < 0) begin
      y_edge = '0;
    end else if (ys > $signed(YS_BITS'(COORD_MAX))) begin
      y_edge = COORD_MAX;
    end else begin
      y_edge = ys[COORD_BITS-1:0];
    end
    col_inc  = next_col_q + COL_CNT_BITS'(1);
    flat_col = (next_col_q > COL_CNT_BITS'(COLUMN_LIMIT - 1))
             ? COL_CNT_BITS'(COLUMN_LIMIT - 1) : next_col_q;
  end

  // Next result: quick answer or finished column
  always_comb begin
    res_d = res_q;
    if (ctrl_i.quick) begin
      res_d = '0;
      if (!active_q) begin
        res_d.past_end = 1'b1;
      end else begin
        res_d.column       = flat_col[COLUMN_BITS-1:0];
        res_d.span_start_y = box_min_q;
        res_d.span_end_y   = box_max_q;
        res_d.drawn        = 1'b1;
        res_d.last_span    = 1'b1;
      end
    end
    if (ctrl_i.cap_short) begin
      res_d.column       = next_col_q[COLUMN_BITS-1:0];
      res_d.span_start_y = ylong_q;
      res_d.span_end_y   = y_edge;
      res_d.drawn        = (ylong_q >= box_min_q) && (ylong_q <= box_max_q) &&
                           (y_edge >= box_min_q) && (y_edge <= box_max_q);
      res_d.last_span    = col_inc >= end_col_q;
      res_d.past_end     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
      end
      loaded_q   <= '0;
      next_col_q <= '0;
      end_col_q  <= '0;
      box_min_q  <= COORD_MAX;
      box_max_q  <= '0;
      active_q   <= 1'b0;
      flat_q     <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      strobe_q <= ctrl_i.quick | ctrl_i.cap_short;
      if (ctrl_i.load) begin
        for (int i = 0; i < 3; i++) begin
          vx_q[i] <= nx[i];
          vy_q[i] <= ny[i];
        end
        box_min_q <= bmin;
        box_max_q <= bmax;
        loaded_q  <= slot + 2'd1;
        if (slot == 2'd2) begin
          next_col_q <= ceil_col(nx[0]);
          end_col_q  <= ceil_col(nx[2]);
          flat_q     <= ceil_col(nx[0]) >= ceil_col(nx[2]);
          active_q   <= 1'b1;
        end else if (loaded_q == 2'd3) begin
          active_q <= 1'b0;
        end
      end
      if (ctrl_i.quick) begin
        if (active_q) begin
          active_q <= 1'b0;
        end
      end
      if (ctrl_i.cap_short) begin
        next_col_q <= col_inc;
        if (col_inc >= end_col_q) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= PROD_BITS'(dy * tt);
      ya_q   <= ya;
      dx_q   <= xb - xa;
    end
    if (ctrl_i.div_start) begin
      neg_q <= nsum[NSUM_BITS-1];
    end
    if (ctrl_i.cap_long) begin
      ylong_q <= y_edge;
    end
    if (ctrl_i.quick || ctrl_i.cap_short) begin
      res_q <= res_d;
    end
  end

  assign status_o.active   = active_q;
  assign status_o.flat     = flat_q;
  assign status_o.div_done = div_done;
  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule
`default_nettype wire

FILE: hdl/tcsf_ctrl.sv
// Controller state machine: sequences vertex loads, quick answers and the long and short edge evaluations of a span.
`default_nettype none
module tcsf_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic                   cmd_i,
  input  wire tcsf_pkg::tcsf_status_t status_i,
  output tcsf_pkg::tcsf_ctrl_t        ctrl_o,
  output logic                        busy_o
);
  import tcsf_pkg::*;

  tcsf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (cmd_i == CMD_LOAD) begin
            ctrl_o.load = 1'b1;
          end else if (!status_i.active || status_i.flat) begin
            ctrl_o.quick = 1'b1;
          end else begin
            state_d = ST_MUL_LONG;
          end
        end
      end
      ST_MUL_LONG: begin
        ctrl_o.mul = 1'b1;
        state_d    = ST_START_LONG;
      end
      ST_START_LONG: begin
        ctrl_o.div_start = 1'b1;
        state_d          = ST_WAIT_LONG;
      end
      ST_WAIT_LONG: begin
        if (status_i.div_done) begin
          ctrl_o.cap_long = 1'b1;
          state_d         = ST_MUL_SHORT;
        end
      end
      ST_MUL_SHORT: begin
        ctrl_o.mul        = 1'b1;
        ctrl_o.edge_short = 1'b1;
        state_d           = ST_START_SHORT;
      end
      ST_START_SHORT: begin
        ctrl_o.div_start = 1'b1;
        state_d          = ST_WAIT_SHORT;
      end
      ST_WAIT_SHORT: begin
        if (status_i.div_done) begin
          ctrl_o.cap_short = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
